// ----- sv/s2dasc_pkg.sv -----
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared definitions
// Widths and character codes used by the conversion core.
// ----------------------------------------------------------------------------
package s2dasc_pkg;

  // Width of the signed input word.
  localparam int unsigned ValueW = 64;

  // Width of one text byte and of one BCD digit.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DigitW = 4;

  // Bit counter for the shift-and-add-3 loop: one step per input bit.
  localparam int unsigned CntW = $clog2(ValueW);
  localparam logic [CntW-1:0] CntLast = CntW'(ValueW - 1);

  // Character codes.
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;

  // Threshold and correction of the add-3 step.
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

endpackage

// ----- sv/signed_int_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// Signed 64-bit integer to decimal ASCII text
// Converts a signed word to BCD with a shared shift-and-add-3 unit, drops
// leading zeros and streams a minus sign and the digits, one byte a word.
// ----------------------------------------------------------------------------
// Steps: shift-and-add-3 over the input bits, one step per bit, then dropping
// of leading zeros, a minus sign if negative, and one byte per digit; a byte
// waits while the output register is full and not taken. The block takes no
// new word while one is in progress; the next word is taken once the last
// byte sits in the output register. Reset empties it and idles the sequencer.
module signed_int_to_decimal_ascii_core #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [s2dasc_pkg::ValueW-1:0] value_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic [s2dasc_pkg::ByteW-1:0]  text_byte_o,
  output logic                          last_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);
  import s2dasc_pkg::*;

  localparam int unsigned BcdW = DigitW * MAX_DIGITS;
  localparam int unsigned RemW = $clog2(MAX_DIGITS + 1);
  localparam logic [RemW-1:0] RemOne = RemW'(1);
  localparam logic [RemW-1:0] RemAll = RemW'(MAX_DIGITS);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   bcd_adj;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              in_fire;
  logic              out_free;
  logic [DigitW-1:0] top_digit;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign top_digit   = bcd_q[BcdW-1 -: DigitW];
  assign out_valid_o = out_valid_q;
  assign text_byte_o = out_byte_q;
  assign last_o      = out_last_q;

  // Shared add-3 unit: correct every BCD digit of five or more before a shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[DigitW*i +: DigitW] >= DabbleLimit) begin
        bcd_adj[DigitW*i +: DigitW] = bcd_q[DigitW*i +: DigitW] + DabbleAdd;
      end else begin
        bcd_adj[DigitW*i +: DigitW] = bcd_q[DigitW*i +: DigitW];
      end
    end
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    // The consumer takes the waiting byte.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          neg_d   = value_i[ValueW-1];
          mag_d   = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
          bcd_d   = '0;
          cnt_d   = CntLast;
          state_d = StConv;
        end
      end
      StConv: begin
        // One magnitude bit enters the BCD register per cycle.
        bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
        mag_d = {mag_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          rem_d   = RemAll;
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zeros but always keep the units digit.
        if (top_digit == '0 && rem_q != RemOne) begin
          bcd_d = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          rem_d = rem_q - RemOne;
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = CharMinus;
          out_last_d  = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = CharZero + ByteW'(top_digit);
          out_last_d  = (rem_q == RemOne);
          bcd_d       = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          rem_d       = rem_q - RemOne;
          if (rem_q == RemOne) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  // An accepted word always starts the conversion loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StConv))
    else $error("accepted word did not start conversion");

  // While converting, any byte still waiting must close the previous text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv && out_valid_o) |-> last_o)
    else $error("unfinished text left pending during conversion");

  // Only a minus sign or a decimal digit is ever presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (text_byte_o == CharMinus ||
                     (text_byte_o >= CharZero && text_byte_o <= CharNine)))
    else $error("illegal character on output");

  // At least one digit remains whenever digits are still to be sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSkip || state_q == StSign || state_q == StEmit) |-> (rem_q != '0))
    else $error("digit count ran out before the last byte");

endmodule
